[rtl/gpd_pkg.sv]
// Gain packet deframer package: byte codes, frame positions, widths and
// the frame record type shared by the front, the queue and the back.
// No dependencies.
package gpd_pkg;

    // Queue depth between the framer and the decoder
    localparam int GPD_FIFO_DEPTH = 2;

    // Byte codes
    localparam logic [7:0] HDR_FIRST  = 8'h53;
    localparam logic [7:0] HDR_SECOND = 8'h4D;
    localparam logic [7:0] TRAILER    = 8'h50;
    localparam logic [7:0] POINT_CHAR = 8'h2E;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] TYPE_FIRST = 8'h41;
    localparam logic [7:0] TYPE_LAST  = 8'h49;

    // Frame positions; also used as point position codes
    localparam logic [2:0] FP_NONE    = 3'd0;
    localparam logic [2:0] FP_TYPE    = 3'd2;
    localparam logic [2:0] FP_CHAR0   = 3'd3;
    localparam logic [2:0] FP_CHAR1   = 3'd4;
    localparam logic [2:0] FP_CHAR2   = 3'd5;
    localparam logic [2:0] FP_CHAR3   = 3'd6;
    localparam logic [2:0] FP_TRAILER = 3'd7;

    // Arithmetic widths
    localparam int DIGIT_W = 9;   // byte minus '0', signed
    localparam int INNER_W = 19;  // weighted digit sum, signed
    localparam int VALUE_W = 29;  // value in thousandths, signed
    localparam int INDEX_W = 4;

    // Hunt / collect state of the framer
    typedef enum logic {
        ST_HUNT,
        ST_COLLECT
    } t_fr_state;

    // Final scale applied to the weighted digit sum
    typedef enum logic [1:0] {
        SC_1,
        SC_10,
        SC_100,
        SC_1000
    } t_scale;

    // One complete frame with a good trailer
    typedef struct packed {
        logic [7:0]      type_byte;
        logic [3:0][7:0] chars;
        logic [2:0]      point_pos;
    } t_frame;

endpackage

[rtl/gain_packet_deframer_top.sv]
// Gain packet deframer top: one byte transfer per cycle while full is low.
// A result shows on the result ports once the frame with the good trailer
// byte has passed the queue, the sum stage and the scale stage.
// full rises only when the frame queue is full, i.e. results are not popped.
// Reset (synchronous, active low) clears hunt state, queue and valid bits.
// Depends on gpd_pkg, gpd_front, gpd_fifo, gpd_back.
module gain_packet_deframer_top
    import gpd_pkg::*;
#(
    parameter int FIFO_DEPTH = GPD_FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_rx_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [INDEX_W-1:0]         o_gain_index,
    output logic signed [VALUE_W-1:0]  o_value_milli,
    output logic                       o_status
);

    logic   accept;
    logic   fr_push, q_full, q_valid, q_pop, out_valid;
    t_frame fr_frame, q_frame;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_valid;

    // Header hunt and frame collection
    gpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_rx_byte    (i_rx_byte),
        .o_frame_push (fr_push),
        .o_frame      (fr_frame)
    );

    // Frame queue
    gpd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_frame (fr_frame),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_frame (q_frame)
    );

    // Value decode and result register
    gpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (q_valid),
        .i_frame       (q_frame),
        .o_frame_pop   (q_pop),
        .o_valid       (out_valid),
        .i_pop         (pop),
        .o_gain_index  (o_gain_index),
        .o_value_milli (o_value_milli),
        .o_status      (o_status)
    );

endmodule

[rtl/gpd_front.sv]
// Gain packet deframer front: header hunt and frame collection, one byte
// per transfer. Hands each frame with a good trailer to the queue.
// Depends on gpd_pkg.
module gpd_front
    import gpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_frame_push,
    output t_frame     o_frame
);

    t_fr_state       r_state, n_state;
    logic [2:0]      r_pos, n_pos;
    logic [2:0]      r_point, n_point;
    logic [7:0]      r_prev;
    logic [7:0]      r_type, n_type;
    logic [3:0][7:0] r_chars, n_chars;
    logic [1:0]      char_idx;

    assign char_idx = 2'(r_pos - FP_CHAR0);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_pos   <= FP_NONE;
            r_point <= FP_NONE;
            r_prev  <= 8'h00;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_point <= n_point;
            if (i_accept) begin
                r_prev <= i_rx_byte;
            end
        end
    end

    // Frame payload, written before it is read
    always_ff @(posedge i_clk) begin
        r_type  <= n_type;
        r_chars <= n_chars;
    end

    // Next state and frame hand-off
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_point      = r_point;
        n_type       = r_type;
        n_chars      = r_chars;
        o_frame_push = 1'b0;
        if (i_accept) begin
            case (r_state)
                ST_HUNT: begin
                    if (r_prev == HDR_FIRST && i_rx_byte == HDR_SECOND) begin
                        n_state = ST_COLLECT;
                        n_pos   = FP_TYPE;
                        n_point = FP_NONE;
                    end
                end
                ST_COLLECT: begin
                    if (r_pos == FP_TYPE) begin
                        n_type = i_rx_byte;
                        n_pos  = FP_CHAR0;
                    end else if (r_pos >= FP_CHAR0 && r_pos <= FP_CHAR3) begin
                        n_chars[char_idx] = i_rx_byte;
                        if (i_rx_byte == POINT_CHAR) begin
                            n_point = r_pos;
                        end
                        n_pos = r_pos + 3'd1;
                    end else begin
                        // trailer: good one emits, either way hunt again
                        o_frame_push = (i_rx_byte == TRAILER);
                        n_state      = ST_HUNT;
                        n_pos        = FP_NONE;
                    end
                end
                default: begin
                    n_state = ST_HUNT;
                end
            endcase
        end
    end

    assign o_frame.type_byte = r_type;
    assign o_frame.chars     = r_chars;
    assign o_frame.point_pos = r_point;

    // A frame is handed off only from the trailer position
    a_push_at_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_push |-> (r_state == ST_COLLECT && r_pos == FP_TRAILER))
        else $error("frame push outside trailer position");

    // The trailer always ends collection
    a_trailer_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state == ST_COLLECT && r_pos == FP_TRAILER)
        |=> (r_state == ST_HUNT && r_pos == FP_NONE))
        else $error("hunt not rearmed after trailer");

    // A header starts collection at the type position
    a_header_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state == ST_HUNT && r_prev == HDR_FIRST
         && i_rx_byte == HDR_SECOND)
        |=> (r_state == ST_COLLECT && r_pos == FP_TYPE && r_point == FP_NONE))
        else $error("header did not start a frame");

endmodule

[rtl/gpd_fifo.sv]
// Gain packet deframer queue: short frame queue between front and back.
// Depends on gpd_pkg.
module gpd_fifo
    import gpd_pkg::*;
#(
    parameter int DEPTH = GPD_FIFO_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_frame o_frame
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_frame             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_frame = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance");

endmodule

[rtl/gpd_back.sv]
// Gain packet deframer back: decodes queued frames in two stages
// (weighted digit sum, then scale) into a result register.
// Depends on gpd_pkg.
module gpd_back
    import gpd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_frame_valid,
    input  t_frame                     i_frame,
    output logic                       o_frame_pop,
    output logic                       o_valid,
    input  logic                       i_pop,
    output logic [INDEX_W-1:0]         o_gain_index,
    output logic signed [VALUE_W-1:0]  o_value_milli,
    output logic                       o_status
);

    localparam logic signed [INNER_W-1:0] K_I10   = 10;
    localparam logic signed [INNER_W-1:0] K_I100  = 100;
    localparam logic signed [INNER_W-1:0] K_I1000 = 1000;
    localparam logic signed [VALUE_W-1:0] K_V10   = 10;
    localparam logic signed [VALUE_W-1:0] K_V100  = 100;
    localparam logic signed [VALUE_W-1:0] K_V1000 = 1000;

    // Stage 1 registers
    logic                       r_s1_valid;
    logic signed [INNER_W-1:0]  r_s1_inner;
    t_scale                     r_s1_scale;
    logic [INDEX_W-1:0]         r_s1_index;
    logic                       r_s1_status;

    // Result registers
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out_value;
    logic [INDEX_W-1:0]         r_out_index;
    logic                       r_out_status;

    logic                       out_ready, s1_ready;
    logic signed [DIGIT_W-1:0]  dig [4];
    logic signed [INNER_W-1:0]  ext [4];
    logic signed [INNER_W-1:0]  n_inner;
    t_scale                     n_scale;
    logic                       known;
    logic signed [VALUE_W-1:0]  s2_ext, n_value;

    assign out_ready   = !r_out_valid || i_pop;
    assign s1_ready    = !r_s1_valid || out_ready;
    assign o_frame_pop = i_frame_valid && s1_ready;

    // Stage 1: digits and weighted sum by point position
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dig[k] = $signed({1'b0, i_frame.chars[k]}) - $signed({1'b0, DIGIT_ZERO});
            ext[k] = INNER_W'(dig[k]);
        end
        case (i_frame.point_pos)
            FP_NONE: begin
                n_inner = ext[0] * K_I1000 + ext[1] * K_I100 + ext[2] * K_I10 + ext[3];
                n_scale = SC_1000;
            end
            FP_CHAR0: begin
                n_inner = ext[1] * K_I100 + ext[2] * K_I10 + ext[3];
                n_scale = SC_1;
            end
            FP_CHAR1: begin
                n_inner = ext[0] * K_I100 + ext[2] * K_I10 + ext[3];
                n_scale = SC_10;
            end
            FP_CHAR2: begin
                n_inner = ext[0] * K_I100 + ext[1] * K_I10 + ext[3];
                n_scale = SC_100;
            end
            default: begin
                // point in the last character slot
                n_inner = '0;
                n_scale = SC_1;
            end
        endcase
        known = (i_frame.type_byte >= TYPE_FIRST) && (i_frame.type_byte <= TYPE_LAST);
    end

    // Stage 2: final scale by a constant
    always_comb begin
        s2_ext = VALUE_W'(r_s1_inner);
        case (r_s1_scale)
            SC_1:    n_value = s2_ext;
            SC_10:   n_value = s2_ext * K_V10;
            SC_100:  n_value = s2_ext * K_V100;
            SC_1000: n_value = s2_ext * K_V1000;
            default: n_value = s2_ext;
        endcase
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_frame_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_frame_pop) begin
            r_s1_inner  <= n_inner;
            r_s1_scale  <= n_scale;
            r_s1_index  <= known ? INDEX_W'(i_frame.type_byte - TYPE_FIRST) : '0;
            r_s1_status <= !known;
        end
        if (out_ready && r_s1_valid) begin
            r_out_value  <= n_value;
            r_out_index  <= r_s1_index;
            r_out_status <= r_s1_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_gain_index  = r_out_index;
    assign o_value_milli = r_out_value;
    assign o_status      = r_out_status;

    // Error results carry index zero
    a_err_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_index == '0))
        else $error("error result with nonzero index");

    // A popped frame reaches stage 1
    a_pop_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_pop |=> r_s1_valid)
        else $error("popped frame lost");

    // Stage 1 moves into a free result register
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_ready) |=> r_out_valid)
        else $error("stage 1 result lost");

endmodule
